[sv/sate_pkg.sv]
// Shared types and constants for the sorted array table engine.
package sate_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_SEARCH  = 3'd3;
  localparam logic [2:0] OP_REVERSE = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_POS  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOT_FND  = 2'd3;

  // Command as held in the front-end queue.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] value;
    logic [3:0]  position;
  } cmd_t;

endpackage

[sv/sate_front.sv]
// Front end: accepts commands and holds them in a short queue.
module sate_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  sate_pkg::cmd_t cmd_i,
  output logic           busy_o,
  output logic           cmd_valid_o,
  output sate_pkg::cmd_t cmd_o,
  input  logic           cmd_pop_i
);
  import sate_pkg::*;

  cmd_t       slot_q [2];
  logic [1:0] fill_q, fill_d;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic       push;

  assign busy_o      = (fill_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    fill_d = fill_q;
    wr_d   = wr_q;
    rd_d   = rd_q;
    if (push) begin
      wr_d = ~wr_q;
    end
    if (cmd_pop_i && cmd_valid_o) begin
      rd_d = ~rd_q;
    end
    fill_d = fill_q + {1'b0, push} - {1'b0, cmd_pop_i && cmd_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      wr_q   <= wr_d;
      rd_q   <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_i;
    end
  end
endmodule

[sv/sate_back.sv]
// Back end: sequencer that walks the element memory for each command.
module sate_back #(
  parameter int DEPTH      = sate_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sate_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  sate_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           done_o,
  output logic [1:0]     status_o,
  output logic [31:0]    data_o,
  output logic [3:0]     index_o,
  output logic [4:0]     count_o
);
  import sate_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = CW + 1;
  localparam int PW = (XW > 4) ? XW : 4;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIND = 4'd1;  // insert or search scan, one entry a cycle
  localparam logic [3:0] S_SHUP = 4'd2;  // insert: move entries up from the top
  localparam logic [3:0] S_TAKE = 4'd3;  // delete or read: take the addressed entry
  localparam logic [3:0] S_SHDN = 4'd4;  // delete: move entries down
  localparam logic [3:0] S_RVA  = 4'd5;  // reverse: hold low word, read high
  localparam logic [3:0] S_RVB  = 4'd6;  // reverse: write high word to low slot
  localparam logic [3:0] S_RVC  = 4'd7;  // reverse: write low word to high slot
  localparam logic [3:0] S_DONE = 4'd8;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q, hold_q, word_q, word_in;
  logic [3:0]            state_q, state_d;
  logic [2:0]            op_q;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         ptr_q, ptr_d, hi_q, hi_d, idx_q, idx_d;
  logic [AW-1:0]         raddr, waddr;
  logic                  we;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] dat_q, dat_d;
  logic [1:0]            st_q, st_d;
  logic                  load, full, pos_bad, greater;
  logic [XW-1:0]         ptr_x, cnt_x, hi_x;

  assign word_in   = DATA_WIDTH'($signed(cmd_i.value));
  assign load      = (state_q == S_IDLE) && cmd_valid_i;
  assign cmd_pop_o = load;
  assign full      = (cnt_q == CW'(DEPTH));
  assign pos_bad   = (PW'(cmd_i.position) >= PW'(cnt_q));
  assign greater   = ($signed(word_q) > $signed(rdata_q));
  assign ptr_x     = XW'(ptr_q);
  assign cnt_x     = XW'(cnt_q);
  assign hi_x      = XW'(hi_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_in;
      op_q   <= cmd_i.op;
    end
    if (state_q == S_RVA) begin
      hold_q <= rdata_q;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    hi_d    = hi_q;
    st_d    = st_q;
    idx_d   = idx_q;
    dat_d   = dat_q;
    raddr   = ptr_q;
    we      = 1'b0;
    waddr   = ptr_q;
    wdata   = word_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          st_d    = ST_OK;
          idx_d   = '0;
          dat_d   = '0;
          ptr_d   = '0;
          state_d = S_DONE;
          case (cmd_i.op)
            OP_APPEND: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                we    = 1'b1;
                waddr = AW'(cnt_q);
                wdata = word_in;
                idx_d = AW'(cnt_q);
                cnt_d = cnt_q + 1'b1;
              end
            end
            OP_INSERT: begin
              if (full) begin
                st_d = ST_FULL;
              end else if (cnt_q == '0) begin
                we    = 1'b1;
                waddr = '0;
                wdata = word_in;
                cnt_d = cnt_q + 1'b1;
              end else begin
                raddr   = '0;
                state_d = S_FIND;
              end
            end
            OP_DELETE, OP_READ: begin
              if (pos_bad) begin
                st_d = ST_BAD_POS;
              end else begin
                raddr   = AW'(cmd_i.position);
                ptr_d   = AW'(cmd_i.position);
                state_d = S_TAKE;
              end
            end
            OP_SEARCH: begin
              if (cnt_q == '0) begin
                st_d = ST_NOT_FND;
              end else begin
                raddr   = '0;
                state_d = S_FIND;
              end
            end
            OP_REVERSE: begin
              if (cnt_q > CW'(1)) begin
                raddr   = '0;
                hi_d    = AW'(cnt_q - 1'b1);
                state_d = S_RVA;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        if (op_q == OP_INSERT) begin
          if (greater && (ptr_x + XW'(1) < cnt_x)) begin
            ptr_d = ptr_q + 1'b1;
            raddr = ptr_q + 1'b1;
          end else begin
            // insertion point found; start moving from the top entry
            idx_d   = greater ? AW'(cnt_q) : ptr_q;
            hi_d    = AW'(cnt_q);
            raddr   = AW'(cnt_q - 1'b1);
            state_d = S_SHUP;
          end
        end else begin
          if (rdata_q == word_q) begin
            idx_d   = ptr_q;
            state_d = S_DONE;
          end else if (ptr_x + XW'(1) < cnt_x) begin
            ptr_d = ptr_q + 1'b1;
            raddr = ptr_q + 1'b1;
          end else begin
            st_d    = ST_NOT_FND;
            state_d = S_DONE;
          end
        end
      end
      S_SHUP: begin
        we = 1'b1;
        if (hi_q == idx_q) begin
          waddr   = idx_q;
          wdata   = word_q;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_DONE;
        end else begin
          waddr = hi_q;
          wdata = rdata_q;
          hi_d  = hi_q - 1'b1;
          raddr = (hi_q > AW'(1)) ? hi_q - AW'(2) : '0;
        end
      end
      S_TAKE: begin
        dat_d = rdata_q;
        if (op_q == OP_READ) begin
          state_d = S_DONE;
        end else if (ptr_x + XW'(1) >= cnt_x) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end else begin
          raddr   = ptr_q + 1'b1;
          state_d = S_SHDN;
        end
      end
      S_SHDN: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = rdata_q;
        if (ptr_x + XW'(2) >= cnt_x) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
          raddr = ptr_q + AW'(2);
        end
      end
      S_RVA: begin
        raddr   = hi_q;
        state_d = S_RVB;
      end
      S_RVB: begin
        we      = 1'b1;
        waddr   = ptr_q;
        wdata   = rdata_q;
        state_d = S_RVC;
      end
      S_RVC: begin
        we    = 1'b1;
        waddr = hi_q;
        wdata = hold_q;
        if (ptr_x + XW'(2) < hi_x) begin
          ptr_d   = ptr_q + 1'b1;
          hi_d    = hi_q - 1'b1;
          raddr   = ptr_q + 1'b1;
          state_d = S_RVA;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      hi_q    <= '0;
      st_q    <= ST_OK;
      idx_q   <= '0;
      dat_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      hi_q    <= hi_d;
      st_q    <= st_d;
      idx_q   <= idx_d;
      dat_q   <= dat_d;
    end
  end

  assign done_o   = (state_q == S_DONE);
  assign status_o = st_q;
  assign data_o   = 32'($signed(dat_q));
  assign index_o  = 4'(idx_q);
  assign count_o  = 5'(cnt_q);
endmodule

[sv/sorted_array_table_engine.sv]
// Top level of the sorted array table engine.
// Sorted array table engine: one command per start/busy transaction, one result
// per command, shown for a single cycle with result_valid_o; the receiver
// cannot stall. Each command passes through the queue to the back end, which
// writes append directly, takes the addressed entry on read, scans and moves
// entries up on insert, takes and moves entries down on delete, scans on
// search and swaps pairs on reverse, all walking the single memory read port.
// A two-entry command queue lets new commands be taken while one executes;
// busy_o rises only when both entries wait.
module sorted_array_table_engine #(
  parameter int DEPTH      = sate_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = sate_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] value_i,
  input  logic [3:0]  position_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] data_o,
  output logic [3:0]  index_o,
  output logic [4:0]  count_o
);
  import sate_pkg::*;

  cmd_t cmd_in, cmd_head;
  logic cmd_valid, cmd_pop;

  assign cmd_in = '{op: opcode_i, value: value_i, position: position_i};

  sate_front u_front (
    .clk_i, .rst_ni, .start_i, .cmd_i(cmd_in), .busy_o,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd_head), .cmd_pop_i(cmd_pop)
  );

  sate_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd_head), .cmd_pop_o(cmd_pop),
    .done_o(result_valid_o), .status_o, .data_o, .index_o, .count_o
  );

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> count_o <= 5'(DEPTH)) else $error("count beyond depth");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result held two cycles");
  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o != ST_OK |-> data_o == 32'd0)
    else $error("data on error");
endmodule

[tb/sv/tb_sorted_array_table_engine.sv]
// Self-checking testbench for the sorted array table engine.
module tb_sorted_array_table_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import sate_pkg::*;

  localparam int NDEPTH = 16;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [3:0]  index;
    logic [4:0]  count;
  } table_result_t;

  class table_scoreboard;
    logic signed [31:0] store [NDEPTH];
    int unsigned        n_valid;
    table_result_t      pending [$];
    int unsigned        n_mismatch;

    function new();
      n_valid = 0;
      n_mismatch = 0;
      foreach (store[k]) store[k] = '0;
    endfunction

    // Compute the result of one accepted transaction and update the shadow table.
    function void note_command(logic [2:0] op, logic signed [31:0] val, logic [3:0] pos);
      table_result_t r;
      int p;
      logic signed [31:0] t;
      r = '0;
      case (op)
        OP_APPEND: begin
          if (n_valid >= NDEPTH) r.status = ST_FULL;
          else begin
            store[n_valid] = val;
            r.index = n_valid[3:0];
            n_valid++;
          end
        end
        OP_INSERT: begin
          if (n_valid >= NDEPTH) r.status = ST_FULL;
          else begin
            p = 0;
            while (p < n_valid && val > store[p]) p++;
            for (int k = n_valid; k > p; k--) store[k] = store[k-1];
            store[p] = val;
            r.index = p[3:0];
            n_valid++;
          end
        end
        OP_DELETE: begin
          if (pos >= n_valid) r.status = ST_BAD_POS;
          else begin
            r.data = store[pos];
            for (int k = pos; k + 1 < n_valid; k++) store[k] = store[k+1];
            n_valid--;
          end
        end
        OP_SEARCH: begin
          r.status = ST_NOT_FND;
          for (int k = 0; k < n_valid; k++)
            if (store[k] == val) begin
              r.status = ST_OK;
              r.index = k[3:0];
              break;
            end
        end
        OP_REVERSE: begin
          for (int k = 0; k < n_valid / 2; k++) begin
            t = store[k];
            store[k] = store[n_valid-1-k];
            store[n_valid-1-k] = t;
          end
        end
        OP_READ: begin
          if (pos >= n_valid) r.status = ST_BAD_POS;
          else r.data = store[pos];
        end
        default: ;
      endcase
      r.count = n_valid[4:0];
      pending.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("mismatch: expected st=%0d data=%h idx=%0d cnt=%0d,",
                   want.status, want.data, want.index, want.count,
                   " got st=%0d data=%h idx=%0d cnt=%0d",
                   got.status, got.data, got.index, got.count);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic [31:0] value = '0;
  logic [3:0]  position = '0;
  logic        res_valid;
  logic [1:0]  status;
  logic [31:0] data;
  logic [3:0]  index;
  logic [4:0]  count;

  table_scoreboard sb = new();
  longint cycles = 0;
  bit quiet_sender = 1'b0;

  always #2 clk = ~clk;

  sorted_array_table_engine i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .opcode_i(opcode), .value_i(value), .position_i(position),
    .result_valid_o(res_valid), .status_o(status), .data_o(data),
    .index_o(index), .count_o(count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && res_valid) sb.check_result({status, data, index, count});

  // Drive one command and hold it until a transaction takes place.
  task automatic issue(logic [2:0] op, logic [31:0] val, logic [3:0] pos);
    while (!quiet_sender && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    value <= val;
    position <= pos;
    do @(posedge clk); while (busy);
    sb.note_command(op, val, pos);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7);
      3: return -$urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] stored_or_random();
    if (sb.n_valid > 0 && $urandom_range(1))
      return sb.store[$urandom_range(sb.n_valid - 1)];
    return rand_word();
  endfunction

  initial begin
    int budget;
    logic [2:0] op;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-table corner cases, then fill past full.
    issue(OP_REVERSE, 32'd0, 4'd0);
    issue(OP_READ, 32'd0, 4'd0);
    issue(OP_DELETE, 32'd0, 4'd15);
    issue(OP_SEARCH, 32'h8000_0000, 4'd0);
    issue(OP_APPEND, 32'h7fff_ffff, 4'd0);
    issue(OP_REVERSE, 32'd0, 4'd0);
    issue(OP_INSERT, 32'h8000_0000, 4'd0);
    issue(OP_INSERT, 32'h7fff_ffff, 4'd0);
    for (int k = 0; k < 13; k++) issue(OP_INSERT, $urandom, 4'd0);
    issue(OP_APPEND, 32'hffff_ffff, 4'd0);
    issue(OP_INSERT, 32'd5, 4'd0);
    issue(OP_SEARCH, 32'hffff_ffff, 4'd0);
    issue(OP_READ, 32'd0, 4'd15);
    issue(OP_DELETE, 32'd0, 4'd15);
    issue(OP_DELETE, 32'd0, 4'd15);
    issue(OP_REVERSE, 32'd0, 4'd0);
    issue(OP_SPARE_A, 32'hffff_ffff, 4'd15);
    issue(OP_SPARE_B, 32'd0, 4'd0);

    for (int k = 0; k < 700; k++) begin
      quiet_sender = (k >= 300 && k < 400);
      budget = $urandom_range(99);
      if (sb.n_valid < 4 && budget < 40) op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
      else if (sb.n_valid > 12 && budget < 40) op = OP_DELETE;
      else op = 3'($urandom_range(7));
      issue(op, (op == OP_SEARCH) ? stored_or_random() : rand_word(),
            (sb.n_valid > 0 && $urandom_range(3) != 0) ?
              4'($urandom_range(sb.n_valid - 1)) : 4'($urandom));
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.n_mismatch == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
